// File: hdl/sorted_address_range_table_core_assert.svh
`ifndef SORTED_ADDRESS_RANGE_TABLE_CORE_ASSERT_SVH
`define SORTED_ADDRESS_RANGE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, held off in reset
`define SART_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sart_pkg.sv
package sart_pkg;

    localparam int ADDRESS_WIDTH   = 32;
    localparam int SYMBOL_WIDTH    = 16;
    localparam int COUNT_OUT_WIDTH = 11;
    localparam int FUNC_WIDTH      = 2;
    localparam int STATUS_WIDTH    = 2;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [FUNC_WIDTH-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FN_LOOKUP = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FN_CLEAR  = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_OUTER = 2'd2;

    // Read address select
    localparam logic [1:0] RS_MID   = 2'd0;
    localparam logic [1:0] RS_PRED  = 2'd1;
    localparam logic [1:0] RS_SHIFT = 2'd2;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0]    func;
        logic [ADDRESS_WIDTH-1:0] key_address;
        logic [SYMBOL_WIDTH-1:0]  symbol_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]    status;
        logic [SYMBOL_WIDTH-1:0]    found_symbol;
        logic [COUNT_OUT_WIDTH-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ADDRESS_WIDTH-1:0] addr;
        logic [SYMBOL_WIDTH-1:0]  sym;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cmp_step;
        logic       shift_wr;
        logic       place;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0] func;
        logic                  full;
        logic                  lo_eq_hi;
        logic                  lo_zero;
        logic                  j_eq_lo;
        logic                  out_free;
    } t_stat;

endpackage

// File: hdl/sart_ctrl.sv
module sart_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sart_pkg::t_stat i_stat,
    output sart_pkg::t_cmd  o_cmd
);
    import sart_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SHWR  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = RS_MID;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.func)
                    FN_INSERT: n_state = i_stat.full ? S_FIN : S_SRCH;
                    FN_LOOKUP: n_state = S_SRCH;
                    FN_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_SRCH: begin
                if (i_stat.lo_eq_hi) begin
                    if (i_stat.func == FN_INSERT) begin
                        n_state = S_SHIFT;
                    end else if (i_stat.lo_zero) begin
                        n_state = S_FIN;
                    end else begin
                        // fetch the last entry not above the query
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RS_PRED;
                        n_state      = S_FIN;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_MID;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp_step = 1'b1;
                n_state        = S_SRCH;
            end
            S_SHIFT: begin
                if (i_stat.j_eq_lo) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_SHIFT;
                    n_state      = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SHIFT;
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hdl/sart_dpath.sv
module sart_dpath #(
    parameter int TABLE_DEPTH = sart_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sart_pkg::t_in_item                   i_in,
    input  logic                                 i_cfg_we,
    input  logic [sart_pkg::SYMBOL_WIDTH-1:0]    i_cfg_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output sart_pkg::t_out_item                  o_out,
    input  sart_pkg::t_cmd                       i_cmd,
    output sart_pkg::t_stat                      o_stat
);
    import sart_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_lo;
    logic [CNT_W-1:0]         r_hi;
    logic [CNT_W-1:0]         r_j;
    logic [FUNC_WIDTH-1:0]    r_func;
    logic [ADDRESS_WIDTH-1:0] r_key;
    logic [SYMBOL_WIDTH-1:0]  r_sym;
    logic                     r_full;
    logic [SYMBOL_WIDTH-1:0]  r_outer;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_lo_m1;
    logic [CNT_W-1:0] w_j_m1;
    logic             w_go_right;
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_wr_idx;
    t_entry           w_wr_data;
    logic             w_wr_en;
    logic             w_full_now;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CNT_W:1];
    assign w_lo_m1    = r_lo - CNT_W'(1);
    assign w_j_m1     = r_j - CNT_W'(1);
    assign w_full_now = (r_count == CNT_W'(TABLE_DEPTH));

    // lookup finds the upper bound, insert the lower bound
    assign w_go_right = (r_func == FN_LOOKUP) ? (r_rd_data.addr <= r_key)
                                              : (r_rd_data.addr <  r_key);

    always_comb begin
        case (i_cmd.rd_sel)
            RS_MID:   w_rd_idx = w_mid[IDX_W-1:0];
            RS_PRED:  w_rd_idx = w_lo_m1[IDX_W-1:0];
            RS_SHIFT: w_rd_idx = w_j_m1[IDX_W-1:0];
            default:  w_rd_idx = w_mid[IDX_W-1:0];
        endcase
    end

    assign w_wr_en   = i_cmd.shift_wr | i_cmd.place;
    assign w_wr_idx  = i_cmd.place ? r_lo[IDX_W-1:0] : r_j[IDX_W-1:0];
    assign w_wr_data = i_cmd.place ? t_entry'{addr: r_key, sym: r_sym} : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_outer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_outer <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in.func;
            r_key  <= i_in.key_address;
            r_sym  <= i_in.symbol_id;
            r_full <= w_full_now;
            r_lo   <= '0;
            r_hi   <= r_count;
            r_j    <= r_count;
        end else begin
            if (i_cmd.cmp_step) begin
                if (w_go_right) begin
                    r_lo <= w_mid + CNT_W'(1);
                end else begin
                    r_hi <= w_mid;
                end
            end
            if (i_cmd.shift_wr) begin
                r_j <= w_j_m1;
            end
        end
        if (i_cmd.finish) begin
            r_out.entry_count  <= COUNT_OUT_WIDTH'(r_count);
            r_out.status       <= ST_OK;
            r_out.found_symbol <= '0;
            case (r_func)
                FN_INSERT: begin
                    if (r_full) begin
                        r_out.status <= ST_FULL;
                    end
                end
                FN_LOOKUP: begin
                    if (r_lo == '0) begin
                        r_out.status       <= ST_OUTER;
                        r_out.found_symbol <= r_outer;
                    end else begin
                        r_out.found_symbol <= r_rd_data.sym;
                    end
                end
                default: r_out.status <= ST_OK;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_stat.func     = r_func;
    assign o_stat.full     = r_full;
    assign o_stat.lo_eq_hi = (r_lo == r_hi);
    assign o_stat.lo_zero  = (r_lo == '0);
    assign o_stat.j_eq_lo  = (r_j == r_lo);
    assign o_stat.out_free = ~r_out_valid | i_out_ready;

endmodule

// File: hdl/sorted_address_range_table_core.sv
// Lookup: the result follows a binary search over the n entries of the single-port
//   table RAM (one read and one compare per step).
// Insert: the same search, then a shift with one RAM read and one write per entry moved;
//   clear and a full-table insert go from dispatch straight to finish. One request at a time.
// Reset (i_rst_n low, synchronous): empties the table, zeroes the outer symbol and drops
//   the output valid; RAM contents are left as they are and need no clearing pass.
module sorted_address_range_table_core #(
    parameter int TABLE_DEPTH = sart_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sart_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sart_pkg::t_out_item               o_out,
    input  logic                              i_cfg_we,
    input  logic [sart_pkg::SYMBOL_WIDTH-1:0] i_cfg_data
);
    import sart_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sart_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sart_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// File: hdl/sart_checker.sv
`include "sorted_address_range_table_core_assert.svh"

module sart_checker #(
    parameter int TABLE_DEPTH = sart_pkg::DEF_TABLE_DEPTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input sart_pkg::t_out_item               o_out
);
    import sart_pkg::*;

    localparam bit WIDE_DEPTH = (TABLE_DEPTH > 2047);

    logic w_in_acc;
    logic w_stall;
    logic w_count_ok;
    logic w_full_clean;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_stall      = o_out_valid && !i_out_ready;
    assign w_count_ok   = WIDE_DEPTH || (o_out.entry_count <= TABLE_DEPTH);
    assign w_full_clean = (o_out.status != ST_FULL) || (o_out.found_symbol == '0);

    // busy after taking a request
    `SART_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !o_in_ready, "ready after accept")

    `SART_ASSERT_NOW(a_count_in_range, o_out_valid, w_count_ok, "entry count above depth")

    `SART_ASSERT_NOW(a_full_no_symbol, o_out_valid, w_full_clean, "symbol on rejected insert")

    `SART_ASSERT_NEXT(a_out_hold, w_stall, o_out_valid && $stable(o_out), "result not held")

endmodule

bind sorted_address_range_table_core sart_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sart_checker (.*);
